[sv/bsd_pkg.sv]
`default_nettype none

package bsd_pkg;

  // Hard ceiling on either image side; the register can only lower it.
  localparam logic [13:0] SIDE_LIMIT     = 14'd8192;
  localparam logic [13:0] MAX_SIDE_RESET = 14'd8192;

  // Header layout: bytes 0..33 hold the fields that are checked.
  localparam logic [31:0] HEADER_BYTES   = 32'd34;
  localparam logic [5:0]  POS_SIG_END    = 6'd1;
  localparam logic [5:0]  POS_OFFSET_END = 6'd13;
  localparam logic [5:0]  POS_DIB_END    = 6'd17;
  localparam logic [5:0]  POS_WIDTH_END  = 6'd21;
  localparam logic [5:0]  POS_HEIGHT_END = 6'd25;
  localparam logic [5:0]  POS_PLANES_END = 6'd27;
  localparam logic [5:0]  POS_BPP_END    = 6'd29;
  localparam logic [5:0]  POS_COMP_END   = 6'd33;

  localparam logic [15:0] BMP_SIGNATURE  = 16'h4D42;
  localparam logic [31:0] DIB_MIN_SIZE   = 32'd40;
  localparam logic [15:0] PLANES_ONE     = 16'd1;
  localparam logic [15:0] BPP_24         = 16'd24;
  localparam logic [15:0] BPP_32         = 16'd32;

  // Result queue between the parser and the output stage.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NOT_BMP    = 3'd1,
    ERR_BAD_HEADER = 3'd2,
    ERR_BAD_DIMS   = 3'd3,
    ERR_BAD_FORMAT = 3'd4,
    ERR_TOO_LARGE  = 3'd5,
    ERR_BAD_OFFSET = 3'd6,
    ERR_TRUNCATED  = 3'd7
  } err_t;

  // Everything one input byte produces: an optional pixel, then an optional
  // end-of-image or error result.
  typedef struct packed {
    logic        has_pixel;
    logic [12:0] px;
    logic [12:0] py;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        has_term;
    kind_t       term_kind;
    logic [13:0] iw;
    logic [13:0] ih;
    err_t        err;
  } bundle_t;

  typedef struct packed {
    kind_t       kind;
    logic [12:0] x;
    logic [12:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [13:0] iw;
    logic [13:0] ih;
    err_t        err;
    logic        run_end;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Byte lane of each header position inside its little-endian field.
  function automatic logic [1:0] lane_of(input logic [5:0] pos);
    logic [1:0] lane;
    lane = 2'd0;
    if (pos inside {6'd1, 6'd3, 6'd7, 6'd9, 6'd11, 6'd15, 6'd19, 6'd23,
                    6'd27, 6'd29, 6'd31}) begin
      lane = 2'd1;
    end else if (pos inside {6'd4, 6'd12, 6'd16, 6'd20, 6'd24, 6'd32}) begin
      lane = 2'd2;
    end else if (pos inside {6'd5, 6'd13, 6'd17, 6'd21, 6'd25, 6'd33}) begin
      lane = 2'd3;
    end
    return lane;
  endfunction

endpackage

`default_nettype wire

[sv/bmp_stream_decoder_core.sv]
// Channel  | Dir | Signals                          | Contents
// ---------+-----+----------------------------------+--------------------------------
// s_       | in  | s_tvalid s_tready s_tdata s_tlast| one file byte; tlast = last byte
// m_       | out | m_tvalid m_tready m_tdata m_tuser| pixel, image done or error
//          |     | m_tlast                          | tlast = last result of a byte
// apb      | in  | psel penable pwrite paddr pwdata | max_side at address 0
//          |     | prdata pready                    |
//
// One file byte is taken per cycle while the result queue has room. A byte
// that yields both a pixel and an end-of-image or error result sends them out
// as two separate results; the four-entry queue between parser and output
// stage absorbs that and any output stall.
// Reset is synchronous; no memory needs clearing.
`default_nettype none

module bmp_stream_decoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // is_final
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [12:0] pixel_x, [25:13] pixel_y, [33:26] red, [41:34] green,
  // [49:42] blue, [63:50] image_width, [77:64] image_height,
  // [80:78] error_code, [87:81] zero
  output logic [87:0]      m_tdata,
  output logic [1:0]       m_tuser,   // [1:0] kind
  output logic             m_tlast,   // run_end
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [13:0]          max_side;
  logic [13:0]          side_lim;
  logic                 q_push;
  logic                 q_pop;
  bsd_pkg::bundle_t     q_in;
  bsd_pkg::bundle_t     q_head;
  bsd_pkg::fifo_stat_t  q_stat;
  bsd_pkg::result_t     res;

  // The register is the only one, so bit 2 of the byte address selects it.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_side <= bsd_pkg::MAX_SIDE_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      max_side <= pwdata[13:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (!paddr[2]) prdata = {18'd0, max_side};
  end

  // The limit in force is the smaller of the register and the hard ceiling.
  assign side_lim = (max_side > bsd_pkg::SIDE_LIMIT) ? bsd_pkg::SIDE_LIMIT : max_side;

  // The parser walks the header and pixel rows, one byte per cycle while the
  // result queue has room, and queues whatever results each byte produces.
  bsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .side_lim (side_lim),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  bsd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // The output stage splits a queued entry into one or two results and holds
  // each in the output register until the sink takes it.
  bsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {7'd0, res.err, res.ih, res.iw, res.blue, res.green, res.red,
                    res.y, res.x};
  assign m_tuser = res.kind;
  assign m_tlast = res.run_end;

endmodule

`default_nettype wire

[sv/bsd_front.sv]
`default_nettype none

module bsd_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,
  input  wire logic                 s_tlast,
  input  wire logic [13:0]          side_lim,
  input  wire bsd_pkg::fifo_stat_t  q_stat,
  output logic                      q_push,
  output bsd_pkg::bundle_t          q_data
);

  typedef enum logic [2:0] {
    PH_HEAD  = 3'b001,
    PH_DATA  = 3'b010,
    PH_DRAIN = 3'b100
  } phase_t;

  typedef struct packed {
    logic sig;
    logic dib;
    logic wbad;
    logic wbig;
    logic hbad;
    logic hbig;
    logic planes;
    logic bpp;
    logic comp;
    logic top;
    logic b32;
  } flags_t;

  localparam flags_t FLAGS_START = '{sig: 1'b0, dib: 1'b0, wbad: 1'b1, wbig: 1'b0,
                                     hbad: 1'b1, hbig: 1'b0, planes: 1'b0,
                                     bpp: 1'b0, comp: 1'b1, top: 1'b0, b32: 1'b0};

  phase_t      phase, phase_next;
  logic [31:0] byte_position, byte_position_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] data_offset, data_offset_next;
  logic [13:0] width_held, width_held_next;
  logic [13:0] height_held, height_held_next;
  flags_t      flags, flags_next;
  logic [13:0] row_count, row_count_next;
  logic [15:0] row_byte_count, row_byte_count_next;
  logic [15:0] row_size, row_size_next;
  logic [15:0] partial_pixel, partial_pixel_next;
  logic [13:0] col_count, col_count_next;
  logic [1:0]  sub_byte, sub_byte_next;

  logic        accept;
  logic [5:0]  pos;
  logic [31:0] v;
  logic [31:0] mag;
  logic [15:0] width_x3;
  logic [15:0] rbc_inc;
  logic [13:0] row_inc;
  logic [2:0]  bpb;
  logic [13:0] y_flip;
  bsd_pkg::err_t err;
  logic        terminal;
  logic        restart;

  function automatic bsd_pkg::err_t evaluate(input flags_t f, input logic [31:0] off);
    bsd_pkg::err_t e;
    if (!f.sig) begin
      e = bsd_pkg::ERR_NOT_BMP;
    end else if (!f.dib) begin
      e = bsd_pkg::ERR_BAD_HEADER;
    end else if (f.wbad || f.hbad || !f.planes) begin
      e = bsd_pkg::ERR_BAD_DIMS;
    end else if (!f.bpp || !f.comp) begin
      e = bsd_pkg::ERR_BAD_FORMAT;
    end else if (f.wbig || f.hbig) begin
      e = bsd_pkg::ERR_TOO_LARGE;
    end else if (off < bsd_pkg::HEADER_BYTES) begin
      e = bsd_pkg::ERR_BAD_OFFSET;
    end else begin
      e = bsd_pkg::ERR_NONE;
    end
    return e;
  endfunction

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign pos      = byte_position[5:0];
  assign width_x3 = {1'b0, width_held, 1'b0} + {2'b00, width_held};
  assign rbc_inc  = row_byte_count + 16'd1;
  assign row_inc  = row_count + 14'd1;
  assign bpb      = flags.b32 ? 3'd4 : 3'd3;
  assign y_flip   = flags.top ? row_count : (height_held - 14'd1 - row_count);

  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    field_shift_next    = field_shift;
    data_offset_next    = data_offset;
    width_held_next     = width_held;
    height_held_next    = height_held;
    flags_next          = flags;
    row_count_next      = row_count;
    row_byte_count_next = row_byte_count;
    row_size_next       = row_size;
    partial_pixel_next  = partial_pixel;
    col_count_next      = col_count;
    sub_byte_next       = sub_byte;
    q_data              = '0;
    err                 = bsd_pkg::ERR_NONE;
    terminal            = 1'b0;
    restart             = 1'b0;
    mag                 = '0;

    case (bsd_pkg::lane_of(pos))
      2'd0:    v = {24'd0, s_tdata};
      2'd1:    v = field_shift | {16'd0, s_tdata, 8'd0};
      2'd2:    v = field_shift | {8'd0, s_tdata, 16'd0};
      default: v = field_shift | {s_tdata, 24'd0};
    endcase

    if (accept) begin
      case (phase)
        PH_HEAD: begin
          field_shift_next   = v;
          byte_position_next = {26'd0, pos} + 32'd1;
          case (pos)
            bsd_pkg::POS_SIG_END: begin
              if (v[15:0] == bsd_pkg::BMP_SIGNATURE) flags_next.sig = 1'b1;
              else err = bsd_pkg::ERR_NOT_BMP;
            end
            bsd_pkg::POS_OFFSET_END: begin
              data_offset_next = v;
            end
            bsd_pkg::POS_DIB_END: begin
              if (v >= bsd_pkg::DIB_MIN_SIZE) flags_next.dib = 1'b1;
              else err = bsd_pkg::ERR_BAD_HEADER;
            end
            bsd_pkg::POS_WIDTH_END: begin
              flags_next.wbad = 1'b0;
              if (v == 32'd0 || v[31]) flags_next.wbad = 1'b1;
              else if (v > {18'd0, side_lim}) flags_next.wbig = 1'b1;
              else width_held_next = v[13:0];
            end
            bsd_pkg::POS_HEIGHT_END: begin
              mag = v[31] ? (32'd0 - v) : v;
              flags_next.hbad = 1'b0;
              if (v == 32'd0) begin
                flags_next.hbad = 1'b1;
              end else begin
                if (v[31]) flags_next.top = 1'b1;
                if (mag > {18'd0, side_lim}) flags_next.hbig = 1'b1;
                else height_held_next = mag[13:0];
              end
            end
            bsd_pkg::POS_PLANES_END: begin
              if (v[15:0] == bsd_pkg::PLANES_ONE) flags_next.planes = 1'b1;
            end
            bsd_pkg::POS_BPP_END: begin
              if (v[15:0] == bsd_pkg::BPP_24) flags_next.bpp = 1'b1;
              if (v[15:0] == bsd_pkg::BPP_32) begin
                flags_next.bpp = 1'b1;
                flags_next.b32 = 1'b1;
              end
            end
            bsd_pkg::POS_COMP_END: begin
              if (v != 32'd0) flags_next.comp = 1'b0;
            end
            default: begin
            end
          endcase
          if (err == bsd_pkg::ERR_NONE && (pos == bsd_pkg::POS_COMP_END || s_tlast)) begin
            err = evaluate(flags_next, data_offset_next);
            if (err == bsd_pkg::ERR_NONE && s_tlast) err = bsd_pkg::ERR_TRUNCATED;
          end
          if (err != bsd_pkg::ERR_NONE) begin
            q_data.has_term  = 1'b1;
            q_data.term_kind = bsd_pkg::KIND_ERROR;
            q_data.err       = err;
            terminal         = 1'b1;
          end else if (pos == bsd_pkg::POS_COMP_END) begin
            phase_next    = PH_DATA;
            row_size_next = flags.b32 ? {width_held, 2'b00}
                                      : ((width_x3 + 16'd3) & ~16'd3);
          end
        end

        PH_DATA: begin
          if (byte_position < data_offset) begin
            byte_position_next = byte_position + 32'd1;
          end else begin
            if (byte_position != '1) byte_position_next = byte_position + 32'd1;
            if (col_count < width_held) begin
              case (sub_byte)
                2'd0: partial_pixel_next = {8'd0, s_tdata};
                2'd1: partial_pixel_next = {s_tdata, partial_pixel[7:0]};
                2'd2: begin
                  q_data.has_pixel = 1'b1;
                  q_data.px        = col_count[12:0];
                  q_data.py        = y_flip[12:0];
                  q_data.red       = s_tdata;
                  q_data.green     = partial_pixel[15:8];
                  q_data.blue      = partial_pixel[7:0];
                end
                default: begin
                end
              endcase
              if (({1'b0, sub_byte} + 3'd1) >= bpb) begin
                sub_byte_next  = 2'd0;
                col_count_next = col_count + 14'd1;
              end else begin
                sub_byte_next = sub_byte + 2'd1;
              end
            end
            row_byte_count_next = rbc_inc;
            if (rbc_inc >= row_size) begin
              row_byte_count_next = '0;
              col_count_next      = '0;
              sub_byte_next       = '0;
              row_count_next      = row_inc;
              if (row_inc >= height_held) begin
                q_data.has_term  = 1'b1;
                q_data.term_kind = bsd_pkg::KIND_DONE;
                q_data.iw        = width_held;
                q_data.ih        = height_held;
                terminal         = 1'b1;
              end
            end
          end
          if (!terminal && s_tlast) begin
            q_data.has_term  = 1'b1;
            q_data.term_kind = bsd_pkg::KIND_ERROR;
            q_data.err       = bsd_pkg::ERR_TRUNCATED;
            terminal         = 1'b1;
          end
        end

        PH_DRAIN: begin
          if (s_tlast) restart = 1'b1;
        end

        default: begin
          restart = 1'b1;
        end
      endcase

      if (terminal) begin
        if (s_tlast) restart = 1'b1;
        else phase_next = PH_DRAIN;
      end

      if (restart) begin
        phase_next          = PH_HEAD;
        byte_position_next  = '0;
        field_shift_next    = '0;
        data_offset_next    = '0;
        width_held_next     = '0;
        height_held_next    = '0;
        flags_next          = FLAGS_START;
        row_count_next      = '0;
        row_byte_count_next = '0;
        partial_pixel_next  = '0;
        col_count_next      = '0;
        sub_byte_next       = '0;
      end
    end
  end

  assign q_push = accept && (q_data.has_pixel || q_data.has_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEAD;
      byte_position  <= '0;
      field_shift    <= '0;
      data_offset    <= '0;
      width_held     <= '0;
      height_held    <= '0;
      flags          <= FLAGS_START;
      row_count      <= '0;
      row_byte_count <= '0;
      row_size       <= '0;
      partial_pixel  <= '0;
      col_count      <= '0;
      sub_byte       <= '0;
    end else begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      field_shift    <= field_shift_next;
      data_offset    <= data_offset_next;
      width_held     <= width_held_next;
      height_held    <= height_held_next;
      flags          <= flags_next;
      row_count      <= row_count_next;
      row_byte_count <= row_byte_count_next;
      row_size       <= row_size_next;
      partial_pixel  <= partial_pixel_next;
      col_count      <= col_count_next;
      sub_byte       <= sub_byte_next;
    end
  end

endmodule

`default_nettype wire

[sv/bsd_fifo.sv]
`default_nettype none

module bsd_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire bsd_pkg::bundle_t     push_data,
  input  wire logic                 pop,
  output bsd_pkg::bundle_t          head,
  output bsd_pkg::fifo_stat_t       stat
);

  bsd_pkg::bundle_t                entries [bsd_pkg::QDEPTH];
  logic [bsd_pkg::QPTR_W-1:0]      wr_ptr;
  logic [bsd_pkg::QPTR_W-1:0]      rd_ptr;
  logic [bsd_pkg::QCNT_W-1:0]      count, count_next;

  assign head       = entries[rd_ptr];
  assign stat.full  = (count == bsd_pkg::QCNT_W'(bsd_pkg::QDEPTH));
  assign stat.empty = (count == '0);

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 1'b1;
    else if (pop && !push) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

[sv/bsd_back.sv]
`default_nettype none

module bsd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bsd_pkg::bundle_t     head,
  input  wire bsd_pkg::fifo_stat_t  q_stat,
  output logic                      pop,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output bsd_pkg::result_t          res
);

  // Set while the head entry's pixel has gone out and its end result waits.
  logic             second, second_next;
  logic             load;
  logic             take_pixel;
  bsd_pkg::result_t res_next;

  assign load       = !res_valid || res_ready;
  assign take_pixel = head.has_pixel && !second;

  always_comb begin
    res_next    = '0;
    second_next = second;
    pop         = 1'b0;
    if (take_pixel) begin
      res_next.kind    = bsd_pkg::KIND_PIXEL;
      res_next.x       = head.px;
      res_next.y       = head.py;
      res_next.red     = head.red;
      res_next.green   = head.green;
      res_next.blue    = head.blue;
      res_next.err     = bsd_pkg::ERR_NONE;
      res_next.run_end = !head.has_term;
    end else begin
      res_next.kind    = head.term_kind;
      res_next.err     = head.err;
      res_next.run_end = 1'b1;
      if (head.term_kind == bsd_pkg::KIND_DONE) begin
        res_next.iw = head.iw;
        res_next.ih = head.ih;
      end
    end
    if (load && !q_stat.empty) begin
      if (take_pixel && head.has_term) begin
        second_next = 1'b1;
      end else begin
        second_next = 1'b0;
        pop         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_stat.empty) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) res_valid <= !q_stat.empty;
      second <= second_next;
    end
  end

endmodule

`default_nettype wire

[test/bmp_stream_decoder_checker.sv]
`timescale 1ns / 1ps

module bmp_stream_decoder_checker #(
  parameter logic [2:0] MAX_SIDE_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // is_final
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [12:0] pixel_x, [25:13] pixel_y, [33:26] red, [41:34] green,
  // [49:42] blue, [63:50] image_width, [77:64] image_height,
  // [80:78] error_code, [87:81] zero
  input  logic [87:0] m_tdata,
  input  logic [1:0]  m_tuser,   // [1:0] kind
  input  logic        m_tlast,   // run_end
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          failures,
  output int          pending
);
  import bsd_pkg::*;

  typedef enum logic [1:0] {STAGE_HEADER, STAGE_PIXELS, STAGE_DRAIN} stage_t;

  stage_t      stage;
  logic [31:0] file_pos;
  logic [31:0] field_acc;
  logic [31:0] pixel_offset;
  logic [13:0] img_w;
  logic [13:0] img_h;
  logic        sig_ok, dib_ok, w_bad, w_big, h_bad, h_big;
  logic        planes_ok, bpp_ok, comp_ok, top_down, is_32;
  logic [13:0] rows_done;
  logic [15:0] row_bytes;
  logic [13:0] col;
  logic [2:0]  sub;
  logic [15:0] bg_bytes;
  logic [13:0] max_side;
  result_t     expected_q[$];

  initial failures = 0;
  initial pending = 0;

  task automatic restart_file();
    stage = STAGE_HEADER;
    file_pos = '0;
    field_acc = '0;
    pixel_offset = '0;
    img_w = '0;
    img_h = '0;
    sig_ok = 1'b0;
    dib_ok = 1'b0;
    w_bad = 1'b1;
    w_big = 1'b0;
    h_bad = 1'b1;
    h_big = 1'b0;
    planes_ok = 1'b0;
    bpp_ok = 1'b0;
    comp_ok = 1'b1;
    top_down = 1'b0;
    is_32 = 1'b0;
    rows_done = '0;
    row_bytes = '0;
    col = '0;
    sub = '0;
    bg_bytes = '0;
  endtask

  // Position of a header byte inside its little-endian field.
  function automatic int unsigned header_lane(input int unsigned p);
    if (p < 2) return p;
    if (p < 6) return p - 2;
    if (p < 10) return (p - 6) % 2;
    if (p < 26) return (p - 10) % 4;
    if (p < 30) return (p - 26) % 2;
    return p - 30;
  endfunction

  task automatic add_result(input kind_t kind, input logic [12:0] x, input logic [12:0] y,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [13:0] iw, input logic [13:0] ih, input err_t code);
    result_t res;
    res.kind = kind;
    res.x = x;
    res.y = y;
    res.red = r;
    res.green = g;
    res.blue = b;
    res.iw = iw;
    res.ih = ih;
    res.err = code;
    res.run_end = 1'b0;
    expected_q.push_back(res);
  endtask

  task automatic decode_byte(input logic [7:0] data, input logic last_byte);
    int unsigned p, lim, mag, bpb, row_size, ypos, lane, first;
    err_t        code;
    logic        ended;
    first = expected_q.size();
    ended = 1'b0;
    code = ERR_NONE;
    case (stage)
      STAGE_HEADER: begin
        p = (file_pos >= HEADER_BYTES) ? HEADER_BYTES - 1 : file_pos;
        lane = header_lane(p);
        if (lane == 0) begin
          field_acc = {24'd0, data};
        end else begin
          field_acc = field_acc | (32'(data) << (8 * lane));
        end
        lim = (max_side > SIDE_LIMIT) ? SIDE_LIMIT : max_side;
        case (p)
          POS_SIG_END: begin
            if (field_acc[15:0] == BMP_SIGNATURE) sig_ok = 1'b1;
            else code = ERR_NOT_BMP;
          end
          POS_OFFSET_END: pixel_offset = field_acc;
          POS_DIB_END: begin
            if (field_acc >= DIB_MIN_SIZE) dib_ok = 1'b1;
            else code = ERR_BAD_HEADER;
          end
          POS_WIDTH_END: begin
            w_bad = 1'b0;
            if (field_acc == 0 || field_acc[31]) w_bad = 1'b1;
            else if (field_acc > lim) w_big = 1'b1;
            else img_w = field_acc[13:0];
          end
          POS_HEIGHT_END: begin
            h_bad = 1'b0;
            mag = field_acc[31] ? (32'd0 - field_acc) : field_acc;
            if (field_acc == 0) begin
              h_bad = 1'b1;
            end else begin
              if (field_acc[31]) top_down = 1'b1;
              if (mag > lim) h_big = 1'b1;
              else img_h = mag[13:0];
            end
          end
          POS_PLANES_END: if (field_acc[15:0] == PLANES_ONE) planes_ok = 1'b1;
          POS_BPP_END: begin
            if (field_acc[15:0] == BPP_24) bpp_ok = 1'b1;
            if (field_acc[15:0] == BPP_32) begin
              bpp_ok = 1'b1;
              is_32 = 1'b1;
            end
          end
          POS_COMP_END: if (field_acc != 0) comp_ok = 1'b0;
          default: ;
        endcase
        file_pos = p + 1;
        // Remaining checks run once the header is in, or early at end of file.
        if (code == ERR_NONE && (p == HEADER_BYTES - 1 || last_byte)) begin
          if (!sig_ok) code = ERR_NOT_BMP;
          else if (!dib_ok) code = ERR_BAD_HEADER;
          else if (w_bad || h_bad || !planes_ok) code = ERR_BAD_DIMS;
          else if (!bpp_ok || !comp_ok) code = ERR_BAD_FORMAT;
          else if (w_big || h_big) code = ERR_TOO_LARGE;
          else if (pixel_offset < HEADER_BYTES) code = ERR_BAD_OFFSET;
          if (code == ERR_NONE && last_byte) code = ERR_TRUNCATED;
        end
        if (code != ERR_NONE) begin
          add_result(KIND_ERROR, '0, '0, '0, '0, '0, '0, '0, code);
          ended = 1'b1;
        end else if (p == HEADER_BYTES - 1) begin
          stage = STAGE_PIXELS;
        end
      end
      STAGE_PIXELS: begin
        if (file_pos < pixel_offset) begin
          file_pos = file_pos + 1;
        end else begin
          bpb = is_32 ? 4 : 3;
          row_size = is_32 ? 32'(img_w) * 4 : ((32'(img_w) * 3 + 3) & ~32'd3);
          if (file_pos != '1) file_pos = file_pos + 1;
          if (col < img_w) begin
            if (sub == 0) begin
              bg_bytes = {8'd0, data};
            end else if (sub == 1) begin
              bg_bytes[15:8] = data;
            end else if (sub == 2) begin
              ypos = top_down ? rows_done : 32'(img_h) - 1 - rows_done;
              add_result(KIND_PIXEL, col[12:0], ypos[12:0], data, bg_bytes[15:8],
                         bg_bytes[7:0], '0, '0, ERR_NONE);
            end
            sub = sub + 1;
            if (sub >= bpb) begin
              sub = '0;
              col = col + 1;
            end
          end
          row_bytes = row_bytes + 1;
          if (row_bytes >= row_size) begin
            row_bytes = '0;
            col = '0;
            sub = '0;
            rows_done = rows_done + 1;
            if (rows_done >= img_h) begin
              add_result(KIND_DONE, '0, '0, '0, '0, '0, img_w, img_h, ERR_NONE);
              ended = 1'b1;
            end
          end
        end
        if (!ended && last_byte) begin
          add_result(KIND_ERROR, '0, '0, '0, '0, '0, '0, '0, ERR_TRUNCATED);
          ended = 1'b1;
        end
      end
      default: if (last_byte) restart_file();
    endcase
    if (ended) begin
      if (last_byte) restart_file();
      else stage = STAGE_DRAIN;
    end
    if (expected_q.size() > first) expected_q[expected_q.size() - 1].run_end = 1'b1;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      max_side = MAX_SIDE_RESET;
      restart_file();
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == MAX_SIDE_ADDR) begin
        max_side = pwdata[13:0];
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result of kind %0d with nothing outstanding", m_tuser);
          failures++;
        end else begin
          want = expected_q.pop_front();
          compare_field("kind", want.kind, m_tuser);
          compare_field("pixel_x", want.x, m_tdata[12:0]);
          compare_field("pixel_y", want.y, m_tdata[25:13]);
          compare_field("red", want.red, m_tdata[33:26]);
          compare_field("green", want.green, m_tdata[41:34]);
          compare_field("blue", want.blue, m_tdata[49:42]);
          compare_field("image_width", want.iw, m_tdata[63:50]);
          compare_field("image_height", want.ih, m_tdata[77:64]);
          compare_field("error_code", want.err, m_tdata[80:78]);
          compare_field("tdata padding", 32'd0, m_tdata[87:81]);
          compare_field("run_end", want.run_end, m_tlast);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

[test/bmp_stream_decoder_core_tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the BMP stream decoder. The decoder is fed whole
// files, one byte per request, while a checker beside it predicts every pixel,
// end-of-image and error result and compares them with what comes out.
module bmp_stream_decoder_core_tb;
  import bsd_pkg::*;

  localparam logic [2:0] MAX_SIDE_ADDR = 3'd0;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int IDLE_PCT      = 31;   // chance per cycle that a side sits idle
  localparam int HOLD_CYCLES   = 300;  // long output stall that backs up the input
  localparam int SETTLE_CYCLES = 8;    // outlasts the output registers plus queue
  localparam int PHASE_BYTES   = 100;
  localparam int RANDOM_PHASES = 6;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  wire logic   s_tready;
  logic [7:0]  s_tdata;   // [7:0] data_byte
  logic        s_tlast;   // is_final
  wire logic   m_tvalid;
  logic        m_tready;
  // [12:0] pixel_x, [25:13] pixel_y, [33:26] red, [41:34] green,
  // [49:42] blue, [63:50] image_width, [77:64] image_height,
  // [80:78] error_code, [87:81] zero
  wire logic [87:0] m_tdata;
  wire logic [1:0]  m_tuser;   // [1:0] kind
  wire logic        m_tlast;   // run_end
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  wire logic [31:0] prdata;
  wire logic   pready;

  // Shared stimulus controls: no_idle switches off random idling on both
  // sides, hold_req asks the output side for one long stall.
  logic        no_idle;
  logic        hold_req;
  int          fail_count;
  int          pending_count;
  int          cycles;

  // The file that is being assembled and then streamed in.
  logic [7:0]  image_file[$];

  bmp_stream_decoder_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  bmp_stream_decoder_checker #(
    .MAX_SIDE_ADDR (MAX_SIDE_ADDR)
  ) i_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .pready   (pready),
    .failures (fail_count),
    .pending  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Output side. It takes results at random, except while idling is off, and
  // once holds off for a long stretch so that the decoder's queue fills and it
  // has to stall the byte stream.
  initial begin
    int   hold_left;
    logic hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Mostly random bytes, with the two extremes given extra weight.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_le(input logic [31:0] value, input int nbytes);
    for (int k = 0; k < nbytes; k++) image_file.push_back(value[8 * k +: 8]);
  endtask

  // Starts a new file with the 34 header bytes that the decoder inspects.
  // File size and the reserved words carry random content.
  task automatic build_header(input logic [31:0] sig, input logic [31:0] offset,
                              input logic [31:0] dib, input logic [31:0] width,
                              input logic [31:0] height, input logic [31:0] planes,
                              input logic [31:0] bpp, input logic [31:0] comp);
    image_file.delete();
    add_le(sig, 2);
    add_le($urandom, 4);
    add_le($urandom, 4);
    add_le(offset, 4);
    add_le(dib, 4);
    add_le(width, 4);
    add_le(height, 4);
    add_le(planes, 2);
    add_le(bpp, 2);
    add_le(comp, 4);
  endtask

  // A well-formed image: header, filler up to the pixel offset, then every row
  // with its padding. A negative height field marks a top-down image.
  task automatic make_image(input int w, input int h, input logic is32, input logic top,
                            input int offset);
    int row_len;
    build_header(BMP_SIGNATURE, offset, DIB_MIN_SIZE, w, top ? -h : h, PLANES_ONE,
                 is32 ? BPP_32 : BPP_24, 0);
    for (int k = HEADER_BYTES; k < offset; k++) image_file.push_back(pick_byte());
    row_len = is32 ? 4 * w : (3 * w + 3) & ~3;
    repeat (h * row_len) image_file.push_back(pick_byte());
  endtask

  task automatic cut_file(input int keep);
    image_file = image_file[0:keep - 1];
  endtask

  // Streams the current file; the last byte carries the end-of-file flag.
  // Valid is left high after the last request so that a following file can
  // continue without a gap; drain_results lowers it.
  task automatic send_file();
    int gap;
    for (int i = 0; i < image_file.size(); i++) begin
      gap = 0;
      if (!no_idle) begin
        while ($urandom_range(99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= image_file[i];
      s_tlast  <= (i == image_file.size() - 1);
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      @(negedge clk);
    end
  endtask

  // Stops the byte stream and waits until every predicted result has come
  // out, then a few more cycles for bytes that cause no result.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_max_side(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_SIDE_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Random file. Most are well-formed images with random content that may end
  // early or carry trailing bytes; the rest have one broken header field.
  task automatic random_file(input int unsigned limit);
    int          w, h, offset;
    logic        is32, top;
    logic [31:0] sig, dib, width, height, planes, bpp, comp;
    w      = $urandom_range(1, 5);
    h      = $urandom_range(1, 4);
    is32   = $urandom_range(1);
    top    = $urandom_range(1);
    offset = ($urandom_range(3) == 0) ? HEADER_BYTES : $urandom_range(35, 60);
    if ($urandom_range(99) < 70) begin
      make_image(w, h, is32, top, offset);
      case ($urandom_range(9))
        0: cut_file($urandom_range(1, image_file.size() - 1));
        1: repeat ($urandom_range(1, 6)) image_file.push_back(pick_byte());
        default: ;
      endcase
    end else begin
      sig    = BMP_SIGNATURE;
      dib    = DIB_MIN_SIZE + $urandom_range(84);
      width  = w;
      height = top ? -h : h;
      planes = PLANES_ONE;
      bpp    = is32 ? BPP_32 : BPP_24;
      comp   = 0;
      case ($urandom_range(9))
        0: sig = $urandom_range(16'hFFFF);
        1: dib = $urandom_range(DIB_MIN_SIZE - 1);
        2: width = $urandom_range(1) ? 32'd0 : $urandom;
        3: height = $urandom_range(1) ? 32'd0 : $urandom;
        4: planes = $urandom_range(16'hFFFF);
        5: bpp = $urandom_range(40);
        6: comp = $urandom_range(1, 3);
        7: offset = $urandom_range(HEADER_BYTES - 1);
        8: width = limit + $urandom_range(1, 3);
        default: height = -(int'(limit) + 1);
      endcase
      build_header(sig, offset, dib, width, height, planes, bpp, comp);
      if ($urandom_range(2) == 0) begin
        cut_file($urandom_range(1, HEADER_BYTES - 1));
      end else begin
        repeat ($urandom_range(4)) image_file.push_back(pick_byte());
      end
    end
  endtask

  initial begin
    int          phase_bytes;
    int unsigned limit;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'd0;
    s_tlast  = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = 3'd0;
    pwdata   = 32'd0;
    no_idle  = 1'b0;
    hold_req = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed files at the reset side limit.
    // A file that ends on its first byte: nothing of the signature is complete.
    image_file.delete();
    image_file.push_back(BMP_SIGNATURE[7:0]);
    send_file();
    // Wrong signature; the bytes after the error are skipped up to end of file.
    build_header(16'h5842, 54, DIB_MIN_SIZE, 2, 2, PLANES_ONE, BPP_24, 0);
    cut_file(5);
    send_file();
    // Info header too short.
    build_header(BMP_SIGNATURE, 54, DIB_MIN_SIZE - 1, 2, 2, PLANES_ONE, BPP_24, 0);
    cut_file(20);
    send_file();
    // Bad dimensions: zero width, negative width, zero height, two planes.
    build_header(BMP_SIGNATURE, 54, DIB_MIN_SIZE, 0, 2, PLANES_ONE, BPP_24, 0);
    send_file();
    build_header(BMP_SIGNATURE, 54, DIB_MIN_SIZE, 32'h8000_0001, 2, PLANES_ONE, BPP_24, 0);
    send_file();
    build_header(BMP_SIGNATURE, 54, DIB_MIN_SIZE, 2, 0, PLANES_ONE, BPP_24, 0);
    send_file();
    build_header(BMP_SIGNATURE, 54, DIB_MIN_SIZE, 2, 2, 2, BPP_24, 0);
    send_file();
    // Bad format: unsupported depth, then compression switched on.
    build_header(BMP_SIGNATURE, 54, DIB_MIN_SIZE, 2, 2, PLANES_ONE, 16, 0);
    send_file();
    build_header(BMP_SIGNATURE, 54, DIB_MIN_SIZE, 2, 2, PLANES_ONE, BPP_24, 1);
    send_file();
    // Too large: wide image, and the most negative height.
    build_header(BMP_SIGNATURE, 54, DIB_MIN_SIZE, 9000, 2, PLANES_ONE, BPP_24, 0);
    send_file();
    build_header(BMP_SIGNATURE, 54, DIB_MIN_SIZE, 2, 32'h8000_0000, PLANES_ONE, BPP_32, 0);
    send_file();
    // Pixel offset pointing into the header.
    build_header(BMP_SIGNATURE, 20, DIB_MIN_SIZE, 2, 2, PLANES_ONE, BPP_24, 0);
    send_file();
    // Bottom-up 24-bit image with row padding, filler and trailing bytes.
    make_image(2, 2, 1'b0, 1'b0, 54);
    repeat (3) image_file.push_back(pick_byte());
    send_file();
    // Top-down 32-bit image with pixels right after the header.
    make_image(3, 2, 1'b1, 1'b1, HEADER_BYTES);
    send_file();
    // File ends inside the compression field: it reads as zero, so the header
    // passes and the file is reported truncated.
    make_image(2, 2, 1'b0, 1'b0, 40);
    cut_file(31);
    send_file();
    // File ends inside the pixel rows.
    make_image(5, 3, 1'b0, 1'b0, 40);
    cut_file(image_file.size() - 7);
    send_file();
    // Single pixel; the image completes on the end-of-file byte itself.
    make_image(1, 1, 1'b0, 1'b1, HEADER_BYTES);
    send_file();

    // Side limit of zero turns every image away.
    drain_results();
    write_max_side(0);
    make_image(1, 1, 1'b0, 1'b0, HEADER_BYTES);
    send_file();
    // Smallest useful limit: one pixel passes, two columns do not.
    drain_results();
    write_max_side(1);
    make_image(1, 1, 1'b1, 1'b0, HEADER_BYTES);
    send_file();
    make_image(2, 1, 1'b0, 1'b0, HEADER_BYTES);
    send_file();
    // Largest register value; the hard ceiling still applies.
    drain_results();
    write_max_side(16383);
    build_header(BMP_SIGNATURE, HEADER_BYTES, DIB_MIN_SIZE, 8192, 1, PLANES_ONE, BPP_24, 0);
    repeat (40) image_file.push_back(pick_byte());
    send_file();
    build_header(BMP_SIGNATURE, HEADER_BYTES, DIB_MIN_SIZE, 8193, 1, PLANES_ONE, BPP_24, 0);
    send_file();
    build_header(BMP_SIGNATURE, HEADER_BYTES, DIB_MIN_SIZE, 1, -8192, PLANES_ONE, BPP_32, 0);
    repeat (20) image_file.push_back(pick_byte());
    send_file();

    // Random files in phases, each with its own side limit. Phase 2 carries
    // the long output stall, phase 3 runs without any idling.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: limit = MAX_SIDE_RESET;
        1: limit = 3;
        2: limit = $urandom_range(1, 16383);
        3: limit = 5;
        4: limit = 16383;
        default: limit = $urandom_range(2, 6);
      endcase
      write_max_side(limit);
      no_idle = (ph == 3);
      if (ph == 2) hold_req = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        random_file(limit);
        phase_bytes += image_file.size();
        send_file();
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[bmp_stream_decoder_core.f]
sv/bsd_pkg.sv
sv/bsd_front.sv
sv/bsd_fifo.sv
sv/bsd_back.sv
sv/bmp_stream_decoder_core.sv
test/bmp_stream_decoder_checker.sv
test/bmp_stream_decoder_core_tb.sv
